// ===== rtl/blse_pkg.sv =====
// Package for the branch, load and store executor.
// Holds field widths, opcodes, status codes, item kinds and the queued item type.
// No dependencies.
`default_nettype none

package blse_pkg;

	localparam int MEM_WORDS_DEF = 256;

	localparam int MODE_W   = 2;
	localparam int ADDR_W   = 8;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int REG_IDX_W = 5;
	localparam int OP_W     = 5;

	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EXEC  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADOP = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	localparam logic [OP_W-1:0] OP_BEQ = 5'h10;
	localparam logic [OP_W-1:0] OP_BNE = 5'h11;
	localparam logic [OP_W-1:0] OP_BGT = 5'h12;
	localparam logic [OP_W-1:0] OP_BGE = 5'h13;
	localparam logic [OP_W-1:0] OP_BLT = 5'h14;
	localparam logic [OP_W-1:0] OP_BLE = 5'h15;
	localparam logic [OP_W-1:0] OP_LD  = 5'h1a;
	localparam logic [OP_W-1:0] OP_ST  = 5'h1d;

	localparam logic [REG_IDX_W-1:0] R_ZERO = 5'd0;
	localparam logic [REG_IDX_W-1:0] R_ONE  = 5'd1;

	localparam logic [2:0] KIND_WRITE       = 3'd0;
	localparam logic [2:0] KIND_READ        = 3'd1;
	localparam logic [2:0] KIND_EXEC        = 3'd2;
	localparam logic [2:0] KIND_RANGE_RW    = 3'd3;
	localparam logic [2:0] KIND_RANGE_FETCH = 3'd4;
	localparam logic [2:0] KIND_BADMODE     = 3'd5;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] data;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/blse_req_if.sv =====
// Request channel of the executor: valid, ready and the request payload.
// Depends on blse_pkg for field widths.
`default_nettype none

interface blse_req_if;
	logic                           valid;
	logic                           ready;
	logic [blse_pkg::MODE_W-1:0]    mode;
	logic [blse_pkg::ADDR_W-1:0]    address;
	logic [blse_pkg::WORD_W-1:0]    data;

	modport source(output valid, mode, address, data, input ready);
	modport sink(input valid, mode, address, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/blse_rsp_if.sv =====
// Response channel of the executor: valid, ready and the result payload.
// Depends on blse_pkg for field widths.
`default_nettype none

interface blse_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [blse_pkg::WORD_W-1:0] next_pc;
	logic [blse_pkg::WORD_W-1:0]        read_data;
	logic [blse_pkg::STATUS_W-1:0]      status;

	modport source(output valid, next_pc, read_data, status, input ready);
	modport sink(input valid, next_pc, read_data, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/blse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module blse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/blse_front.sv =====
// Front end: takes request beats and classifies them into queued items.
// Depends on blse_pkg and blse_req_if.
`default_nettype none

module blse_front #(
	parameter int MEM_WORDS = blse_pkg::MEM_WORDS_DEF
) (
	blse_req_if.sink                req,
	input  wire logic               full,
	input  wire logic               clearing,
	output logic                    push,
	output blse_pkg::item_t         push_item
);

	localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);

	logic addr_ok;

	assign req.ready = !full && !clearing;
	assign push      = req.valid && req.ready;
	assign addr_ok   = 32'(req.address) < MEM_LIMIT;

	always_comb begin
		push_item.address = req.address;
		push_item.data    = req.data;
		unique case (req.mode)
			blse_pkg::MODE_WRITE: begin
				push_item.kind = addr_ok ? blse_pkg::KIND_WRITE : blse_pkg::KIND_RANGE_RW;
			end
			blse_pkg::MODE_READ: begin
				push_item.kind = addr_ok ? blse_pkg::KIND_READ : blse_pkg::KIND_RANGE_RW;
			end
			blse_pkg::MODE_EXEC: begin
				push_item.kind = addr_ok ? blse_pkg::KIND_EXEC : blse_pkg::KIND_RANGE_FETCH;
			end
			default: begin
				push_item.kind = blse_pkg::KIND_BADMODE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/blse_fifo.sv =====
// Two-entry queue of classified items between the front end and the back end.
// Depends on blse_pkg.
`default_nettype none

module blse_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire blse_pkg::item_t  push_item,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output blse_pkg::item_t       head
);

	blse_pkg::item_t ent_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/blse_back.sv =====
// Back end: sequencer that owns the word memory and the register file and
// carries out queued items. Depends on blse_pkg, blse_rsp_if and blse_ram.
`default_nettype none

module blse_back #(
	parameter int MEM_WORDS = blse_pkg::MEM_WORDS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             empty,
	input  wire blse_pkg::item_t  head,
	output logic                  pop,
	output logic                  clearing,
	blse_rsp_if.source            rsp
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);
	localparam logic [31:0]   MEM_LIMIT = 32'(MEM_WORDS);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MEMRD = 4'd2;
	localparam logic [3:0] S_FETCH = 4'd3;
	localparam logic [3:0] S_REGA  = 4'd4;
	localparam logic [3:0] S_REGB  = 4'd5;
	localparam logic [3:0] S_EXEC  = 4'd6;
	localparam logic [3:0] S_LOAD  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [31:0]   valid_q;
	logic          rsp_valid_q;

	logic [7:0]    pc_q;
	logic [31:0]   instr_q;
	logic [31:0]   rdv_q;
	logic [31:0]   rsv_q;
	logic [31:0]   opnd_q;
	logic [31:0]   res_pc_q;
	logic [31:0]   res_rd_q;
	logic [1:0]    res_st_q;
	logic [31:0]   next_pc_q;
	logic [31:0]   read_data_q;
	logic [1:0]    status_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	logic          rf_we;
	logic [4:0]    rfa_raddr;
	logic [4:0]    rfb_raddr;
	logic [31:0]   rfa_rdata;
	logic [31:0]   rfb_rdata;

	logic [4:0]    op;
	logic [4:0]    rd_f;
	logic [4:0]    rs_f;
	logic [4:0]    rt_f;
	logic [31:0]   imm_sx;
	logic [31:0]   pc1;
	logic [31:0]   target;
	logic [31:0]   ea;
	logic          ea_ok;
	logic          is_br;
	logic          is_mem;
	logic          take;
	logic          rsp_load;

	// Entries that were never written read as zero; R0 and R1 are constant.
	function automatic logic [31:0] reg_fix(input logic [4:0] idx, input logic vld,
			input logic [31:0] raw);
		logic [31:0] v;
		v = vld ? raw : 32'd0;
		if (idx == blse_pkg::R_ZERO) begin
			v = 32'd0;
		end else if (idx == blse_pkg::R_ONE) begin
			v = 32'd1;
		end
		return v;
	endfunction

	assign op     = instr_q[30:26];
	assign rd_f   = instr_q[25:21];
	assign rs_f   = instr_q[20:16];
	assign rt_f   = instr_q[15:11];
	assign imm_sx = {{16{instr_q[15]}}, instr_q[15:0]};
	assign pc1    = 32'(pc_q) + 32'd1;
	assign target = pc1 + opnd_q;
	assign ea     = rsv_q + opnd_q;
	assign ea_ok  = !ea[31] && (ea < MEM_LIMIT);
	assign is_mem = (op == blse_pkg::OP_LD) || (op == blse_pkg::OP_ST);

	always_comb begin
		is_br = 1'b1;
		unique case (op)
			blse_pkg::OP_BEQ: take = $signed(rdv_q) == $signed(rsv_q);
			blse_pkg::OP_BNE: take = $signed(rdv_q) != $signed(rsv_q);
			blse_pkg::OP_BGT: take = $signed(rdv_q) > $signed(rsv_q);
			blse_pkg::OP_BGE: take = $signed(rdv_q) >= $signed(rsv_q);
			blse_pkg::OP_BLT: take = $signed(rdv_q) < $signed(rsv_q);
			blse_pkg::OP_BLE: take = $signed(rdv_q) <= $signed(rsv_q);
			default: begin
				take  = 1'b0;
				is_br = 1'b0;
			end
		endcase
	end

	assign clearing = state_q == S_CLEAR;
	assign pop      = (state_q == S_IDLE) && !empty;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign rf_we    = (state_q == S_LOAD) && (rd_f != blse_pkg::R_ZERO)
		&& (rd_f != blse_pkg::R_ONE);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 32'd0;
		mem_raddr = AW'(head.address);
		rfa_raddr = rt_f;
		rfb_raddr = rs_f;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				if (!empty && head.kind == blse_pkg::KIND_WRITE) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(head.address);
					mem_wdata = head.data;
				end
			end
			S_FETCH: begin
				rfa_raddr = mem_rdata[25:21];
				rfb_raddr = mem_rdata[20:16];
			end
			S_EXEC: begin
				mem_raddr = ea[AW-1:0];
				if (op == blse_pkg::OP_ST && ea_ok) begin
					mem_we    = 1'b1;
					mem_waddr = ea[AW-1:0];
					mem_wdata = rdv_q;
				end
			end
			default: begin
			end
		endcase
	end

	blse_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	// Two banks written alike give two register reads per cycle.
	blse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rd_f), .wdata(mem_rdata),
		.raddr(rfa_raddr), .rdata(rfa_rdata)
	);

	blse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rd_f), .wdata(mem_rdata),
		.raddr(rfb_raddr), .rdata(rfb_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			valid_q     <= 32'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (rf_we) begin
				valid_q[rd_f] <= 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!empty) begin
						unique case (head.kind)
							blse_pkg::KIND_READ: state_q <= S_MEMRD;
							blse_pkg::KIND_EXEC: state_q <= S_FETCH;
							default:             state_q <= S_DONE;
						endcase
					end
				end
				S_MEMRD: state_q <= S_DONE;
				S_FETCH: state_q <= S_REGA;
				S_REGA:  state_q <= S_REGB;
				S_REGB:  state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= (op == blse_pkg::OP_LD && ea_ok) ? S_LOAD : S_DONE;
				end
				S_LOAD: state_q <= S_DONE;
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			next_pc_q   <= res_pc_q;
			read_data_q <= res_rd_q;
			status_q    <= res_st_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (!empty) begin
					pc_q     <= head.address;
					res_pc_q <= 32'd0;
					res_rd_q <= 32'd0;
					res_st_q <= blse_pkg::ST_OK;
					unique case (head.kind)
						blse_pkg::KIND_RANGE_RW: res_st_q <= blse_pkg::ST_RANGE;
						blse_pkg::KIND_RANGE_FETCH: begin
							res_pc_q <= 32'(head.address);
							res_st_q <= blse_pkg::ST_RANGE;
						end
						blse_pkg::KIND_BADMODE: res_st_q <= blse_pkg::ST_BADOP;
						default: begin
						end
					endcase
				end
			end
			S_MEMRD: res_rd_q <= mem_rdata;
			S_FETCH: instr_q <= mem_rdata;
			S_REGA: begin
				rdv_q <= reg_fix(rd_f, valid_q[rd_f], rfa_rdata);
				rsv_q <= reg_fix(rs_f, valid_q[rs_f], rfb_rdata);
			end
			S_REGB: begin
				opnd_q <= instr_q[31] ? imm_sx : reg_fix(rt_f, valid_q[rt_f], rfa_rdata);
			end
			S_EXEC: begin
				if (is_br) begin
					res_pc_q <= take ? target : pc1;
				end else if (is_mem) begin
					res_pc_q <= pc1;
					res_st_q <= ea_ok ? blse_pkg::ST_OK : blse_pkg::ST_RANGE;
				end else begin
					res_pc_q <= 32'(pc_q);
					res_st_q <= blse_pkg::ST_BADOP;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.next_pc   = $signed(next_pc_q);
	assign rsp.read_data = read_data_q;
	assign rsp.status    = status_q;

endmodule

`default_nettype wire

// ===== rtl/branch_load_store_executor_unit.sv =====
// Top level of the branch, load and store executor.
// Depends on blse_pkg, blse_req_if, blse_rsp_if, blse_front, blse_fifo and blse_back.
//
// Usage: each request beat on req carries mode, address and data. Mode 0 writes a
// word into the word memory, mode 1 reads one back, mode 2 executes the instruction
// stored at the address. Each request gives exactly one response beat on rsp with
// next_pc, read_data and status, in request order.
// After reset the word memory is cleared one word per cycle; req.ready stays low
// until the clearing is done. The register file needs no clearing.
// A write or an out-of-range or invalid request goes from the idle state straight
// to the done state, a read passes through the memory read state, and an executed
// instruction through fetch, REGA, REGB and execute, a load in range also through LOAD.
// The back end handles one item at a time and pops no new item until it is idle.
// A two-entry queue lets the front end take up to two further requests while a
// response waits in the output register; when the receiver holds rsp.ready low the
// back end holds its next result and req.ready drops once the queue is full.
`default_nettype none

module branch_load_store_executor_unit #(
	parameter int MEM_WORDS = blse_pkg::MEM_WORDS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	blse_req_if.sink   req,
	blse_rsp_if.source rsp
);

	logic            push;
	blse_pkg::item_t push_item;
	logic            pop;
	logic            full;
	logic            empty;
	blse_pkg::item_t head;
	logic            clearing;

	blse_front #(.MEM_WORDS(MEM_WORDS)) u_front (
		.req(req), .full(full), .clearing(clearing),
		.push(push), .push_item(push_item)
	);

	blse_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .full(full), .empty(empty), .head(head)
	);

	blse_back #(.MEM_WORDS(MEM_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head),
		.pop(pop), .clearing(clearing), .rsp(rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/blse_chk.sv =====
// Port-level checker for the executor and the bind that attaches it to the top level.
// Depends on blse_pkg and branch_load_store_executor_unit.
`default_nettype none

module blse_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] next_pc,
	input wire logic [31:0] read_data,
	input wire logic [1:0]  status
);

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(next_pc) && $stable(read_data) && $stable(status))
		else $error("response payload changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status == blse_pkg::ST_OK || status == blse_pkg::ST_BADOP
			|| status == blse_pkg::ST_RANGE)
		else $error("response status is not a defined code");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_data != 32'd0 |-> status == blse_pkg::ST_OK && next_pc == 32'd0)
		else $error("read data returned outside a successful read");

endmodule

bind branch_load_store_executor_unit blse_chk u_blse_chk (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.next_pc(rsp.next_pc), .read_data(rsp.read_data), .status(rsp.status)
);

`default_nettype wire

// ===== sim/tb_branch_load_store_executor_unit.sv =====
// Testbench for branch_load_store_executor_unit: memory writes, reads and executed
// branch, load and store instructions, checked beat by beat against a local predictor.
// Depends on blse_pkg, blse_req_if, blse_rsp_if and the executor RTL.
`default_nettype none

module tb_branch_load_store_executor_unit;
	import blse_pkg::*;

	localparam int MEM_WORDS = MEM_WORDS_DEF;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
	localparam logic [OP_W-1:0]   OP_NONE   = 5'h00;

	typedef struct {
		logic signed [WORD_W-1:0] next_pc;
		logic [WORD_W-1:0]        read_data;
		logic [STATUS_W-1:0]      status;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	blse_req_if req();
	blse_rsp_if rsp();

	branch_load_store_executor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	logic [WORD_W-1:0] mem_image [MEM_WORDS];
	logic [WORD_W-1:0] reg_image [32];
	exec_result_t      results_due [$];
	int                beats_sent = 0;
	int                mismatches = 0;
	bit                allow_idle = 1'b1;
	int unsigned       stall_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic exec_result_t run_request(input logic [MODE_W-1:0] mode,
			input logic [ADDR_W-1:0] address, input logic [WORD_W-1:0] data);
		exec_result_t r;
		logic [WORD_W-1:0] word, operand, ea, target;
		logic [OP_W-1:0] op;
		logic [REG_IDX_W-1:0] rd, rs, rt;
		logic take;
		r.next_pc = '0;
		r.read_data = '0;
		r.status = ST_OK;
		case (mode)
			MODE_WRITE: mem_image[address] = data;
			MODE_READ: r.read_data = mem_image[address];
			MODE_EXEC: begin
				word = mem_image[address];
				op = word[30:26];
				rd = word[25:21];
				rs = word[20:16];
				rt = word[15:11];
				operand = word[31] ? {{16{word[15]}}, word[15:0]} : reg_image[rt];
				target = 32'(address) + 32'd1;
				take = 1'b0;
				case (op)
					OP_BEQ: take = $signed(reg_image[rd]) == $signed(reg_image[rs]);
					OP_BNE: take = $signed(reg_image[rd]) != $signed(reg_image[rs]);
					OP_BGT: take = $signed(reg_image[rd]) > $signed(reg_image[rs]);
					OP_BGE: take = $signed(reg_image[rd]) >= $signed(reg_image[rs]);
					OP_BLT: take = $signed(reg_image[rd]) < $signed(reg_image[rs]);
					OP_BLE: take = $signed(reg_image[rd]) <= $signed(reg_image[rs]);
					OP_LD, OP_ST: begin
						ea = reg_image[rs] + operand;
						if (ea >= 32'(MEM_WORDS))
							r.status = ST_RANGE;
						else if (op == OP_LD)
							reg_image[rd] = mem_image[ea[ADDR_W-1:0]];
						else
							mem_image[ea[ADDR_W-1:0]] = reg_image[rd];
					end
					default: begin
						r.status = ST_BADOP;
						target = 32'(address);
					end
				endcase
				if (take)
					target = 32'(address) + 32'd1 + operand;
				reg_image[R_ZERO] = '0;
				reg_image[R_ONE] = 32'd1;
				r.next_pc = target;
			end
			default: r.status = ST_BADOP;
		endcase
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] instr_imm(input logic [OP_W-1:0] op,
			input logic [REG_IDX_W-1:0] rd, input logic [REG_IDX_W-1:0] rs,
			input logic [15:0] imm);
		return {1'b1, op, rd, rs, imm};
	endfunction

	function automatic logic [WORD_W-1:0] instr_reg(input logic [OP_W-1:0] op,
			input logic [REG_IDX_W-1:0] rd, input logic [REG_IDX_W-1:0] rs,
			input logic [REG_IDX_W-1:0] rt);
		return {1'b0, op, rd, rs, rt, 11'($urandom)};
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'($urandom_range(0, MEM_WORDS - 1));
			4: return 32'($urandom_range(0, 31)) - 32'd16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] random_instr();
		logic [OP_W-1:0] op;
		logic [REG_IDX_W-1:0] rs;
		logic [15:0] imm;
		case ($urandom_range(0, 7))
			0: op = OP_BEQ;
			1: op = OP_BNE;
			2: op = OP_BGT;
			3: op = OP_BGE;
			4: op = OP_BLT;
			5: op = OP_BLE;
			6: op = OP_LD;
			default: op = OP_ST;
		endcase
		if ($urandom_range(0, 9) == 0)
			op = 5'($urandom);
		rs = ($urandom_range(0, 2) == 0) ? R_ZERO : 5'($urandom);
		if ($urandom_range(0, 2) == 0)
			return instr_reg(op, 5'($urandom), rs, 5'($urandom));
		if ($urandom_range(0, 3) == 0)
			imm = 16'($urandom);
		else
			imm = 16'($urandom_range(0, 63)) - 16'd16;
		return instr_imm(op, 5'($urandom), rs, imm);
	endfunction

	task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] address,
			input logic [WORD_W-1:0] data);
		req.valid <= 1'b1;
		req.mode <= mode;
		req.address <= address;
		req.data <= data;
		do @(posedge clk); while (!req.ready);
		results_due.push_back(run_request(mode, address, data));
		beats_sent++;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		req.valid <= 1'b0;
		do @(posedge clk); while (results_due.size() != 0);
	endtask

	task automatic test_memory_access();
		send_beat(MODE_WRITE, 8'd0, 32'hFFFF_FFFF);
		send_beat(MODE_WRITE, 8'hFF, 32'h8000_0001);
		send_beat(MODE_READ, 8'd0, 32'h0);
		send_beat(MODE_READ, 8'hFF, 32'hFFFF_FFFF);
		send_beat(MODE_READ, 8'd128, 32'h0);
		send_beat(MODE_NONE, 8'hFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_signed_branches();
		send_beat(MODE_WRITE, 8'd10, 32'h8000_0000);
		send_beat(MODE_WRITE, 8'd11, 32'h7FFF_FFFF);
		send_beat(MODE_WRITE, 8'd20, instr_imm(OP_LD, 5'd2, R_ZERO, 16'd10));
		send_beat(MODE_EXEC, 8'd20, 32'h0);
		send_beat(MODE_WRITE, 8'd21, instr_imm(OP_LD, 5'd3, R_ZERO, 16'd11));
		send_beat(MODE_EXEC, 8'd21, 32'h0);
		// The most negative word sits below the most positive one; the target is behind.
		send_beat(MODE_WRITE, 8'd30, instr_imm(OP_BLT, 5'd2, 5'd3, 16'hFFF0));
		send_beat(MODE_EXEC, 8'd30, 32'h0);
		// A register operand of the largest positive word makes the target wrap.
		send_beat(MODE_WRITE, 8'd40, instr_reg(OP_BEQ, 5'd3, 5'd3, 5'd3));
		send_beat(MODE_EXEC, 8'd40, 32'h0);
	endtask

	task automatic test_load_store_faults();
		send_beat(MODE_WRITE, 8'd50, instr_imm(OP_LD, R_ONE, R_ZERO, 16'd10));
		send_beat(MODE_EXEC, 8'd50, 32'h0);
		send_beat(MODE_WRITE, 8'd51, instr_imm(OP_ST, 5'd2, 5'd3, 16'd1));
		send_beat(MODE_EXEC, 8'd51, 32'h0);
		send_beat(MODE_WRITE, 8'd52, instr_imm(OP_LD, 5'd4, R_ZERO, 16'h0100));
		send_beat(MODE_EXEC, 8'd52, 32'h0);
		send_beat(MODE_WRITE, 8'd53, instr_imm(OP_NONE, 5'd4, 5'd2, 16'hFFFF));
		send_beat(MODE_EXEC, 8'd53, 32'h0);
	endtask

	task automatic run_random_programs(input int until_beats);
		int pick;
		logic [ADDR_W-1:0] data_at, prog_at;
		while (beats_sent < until_beats) begin
			pick = $urandom_range(0, 99);
			data_at = 8'($urandom);
			prog_at = 8'($urandom);
			if (pick < 30) begin
				send_beat(MODE_WRITE, data_at, pick_word());
				send_beat(MODE_WRITE, prog_at,
					instr_imm(OP_LD, 5'($urandom), R_ZERO, {8'h00, data_at}));
				send_beat(MODE_EXEC, prog_at, $urandom);
			end else if (pick < 70) begin
				send_beat(MODE_WRITE, prog_at, random_instr());
				send_beat(MODE_EXEC, prog_at, $urandom);
			end else if (pick < 85) begin
				send_beat(MODE_WRITE, prog_at,
					instr_imm(OP_ST, 5'($urandom), R_ZERO, {8'h00, data_at}));
				send_beat(MODE_EXEC, prog_at, $urandom);
				send_beat(MODE_READ, data_at, $urandom);
			end else begin
				send_beat(2'($urandom), 8'($urandom), $urandom);
			end
		end
	endtask

	task automatic test_random_programs();
		run_random_programs(beats_sent + 750);
	endtask

	task automatic test_drain_pause();
		hold_until_drained();
		run_random_programs(beats_sent + 750);
	endtask

	task automatic test_back_to_back();
		allow_idle = 1'b0;
		run_random_programs(beats_sent + 200);
	endtask

	always @(posedge clk) begin
		exec_result_t due;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (results_due.size() == 0) begin
				$error("response beat arrived with no request outstanding");
				mismatches++;
			end else begin
				due = results_due.pop_front();
				if (rsp.next_pc !== due.next_pc) begin
					$error("next_pc expected %0d, got %0d", due.next_pc, rsp.next_pc);
					mismatches++;
				end
				if (rsp.read_data !== due.read_data) begin
					$error("read_data expected 0x%08h, got 0x%08h", due.read_data,
						rsp.read_data);
					mismatches++;
				end
				if (rsp.status !== due.status) begin
					$error("status expected %0d, got %0d", due.status, rsp.status);
					mismatches++;
				end
			end
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else if (allow_idle && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 4);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		req.valid = 1'b0;
		req.mode = MODE_WRITE;
		req.address = '0;
		req.data = '0;
		rsp.ready = 1'b0;
		foreach (mem_image[i])
			mem_image[i] = '0;
		foreach (reg_image[i])
			reg_image[i] = '0;
		reg_image[R_ONE] = 32'd1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_memory_access();
		test_signed_branches();
		test_load_store_faults();
		test_random_programs();
		test_drain_pause();
		test_back_to_back();

		hold_until_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
